// File: rtl/prm_pkg.sv
// Shared constants, types and state encodings for the power residue mask block.
`default_nettype none

package prm_pkg;

  // Field widths of the channels
  localparam int unsigned MOD_W        = 8;
  localparam int unsigned EXP_W        = 16;
  localparam int unsigned HALF_W       = 64;
  localparam int unsigned SET_W        = 2 * HALF_W;
  localparam int unsigned BIT_W        = $clog2(EXP_W);

  // Default width of the residue set
  localparam int unsigned SET_BITS_DEF = 128;
  localparam int unsigned IDX_W_DEF    = $clog2(SET_BITS_DEF);

  // Top-level sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SETUP,
    ST_START,
    ST_SQW,
    ST_MUL,
    ST_MULW,
    ST_NEXT,
    ST_DONE
  } prm_state_e;

  // Modular multiplier states
  typedef enum logic [2:0] {
    MM_IDLE,
    MM_DIV,
    MM_QUO,
    MM_QP,
    MM_FIX
  } mm_state_e;

  // Commands to the modular multiplier
  typedef struct packed {
    logic setup;  // compute the reciprocal of the modulus
    logic start;  // multiply a by b modulo p
  } mm_ctl_t;

  // Status from the modular multiplier
  typedef struct packed {
    logic busy;
    logic done;   // one-cycle pulse: setup finished or product ready
  } mm_stat_t;

endpackage

`default_nettype wire

// File: rtl/prm_in_if.sv
// Request channel: modulus and exponent with valid/ready.
`default_nettype none

interface prm_in_if;
  import prm_pkg::*;

  logic             valid;
  logic             ready;
  logic [MOD_W-1:0] modulus;
  logic [EXP_W-1:0] exponent;

  modport source (output valid, output modulus, output exponent, input ready);
  modport sink   (input valid, input modulus, input exponent, output ready);
endinterface

`default_nettype wire

// File: rtl/prm_out_if.sv
// Result channel: the residue set as two halves with valid/ready.
`default_nettype none

interface prm_out_if;
  import prm_pkg::*;

  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] set_low;
  logic [HALF_W-1:0] set_high;

  modport source (output valid, output set_low, output set_high, input ready);
  modport sink   (input valid, input set_low, input set_high, output ready);
endinterface

`default_nettype wire

// File: rtl/prm_modmul.sv
// Iterative modular multiplier: Barrett reduction around one shared multiplier.
`default_nettype none

module prm_modmul #(
  parameter int unsigned VW = prm_pkg::IDX_W_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  prm_pkg::mm_ctl_t  ctl_i,
  input  logic [VW:0]       mod_i,
  input  logic [VW-1:0]     a_i,
  input  logic [VW-1:0]     b_i,
  output prm_pkg::mm_stat_t stat_o,
  output logic [VW-1:0]     res_o
);
  import prm_pkg::*;

  localparam int unsigned S  = 2 * VW;   // product width, a*b < 2^S
  localparam int unsigned OW = S + 1;    // multiplier operand width
  localparam int unsigned CW = $clog2(S + 1);

  mm_state_e       state_q, state_d;
  logic [OW-1:0]   recip_q, recip_d;     // floor(2^S / p)
  logic [VW:0]     rem_q, rem_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [S-1:0]    x_q, q_q, qp_q;
  logic [VW-1:0]   res_q, res_d;
  logic            done_q, done_d;

  logic [OW-1:0]   opa, opb;
  logic [2*OW-1:0] prod;
  logic [VW+1:0]   shift_rem;
  logic            rem_ge;
  logic [S-1:0]    diff;
  logic [VW:0]     diff_n;

  // Shared multiplier, operands picked by phase
  always_comb begin
    opa = '0;
    opb = '0;
    case (state_q)
      MM_IDLE: begin
        opa = OW'(a_i);
        opb = OW'(b_i);
      end
      MM_QUO: begin
        opa = OW'(x_q);
        opb = recip_q;
      end
      MM_QP: begin
        opa = OW'(q_q);
        opb = OW'(mod_i);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod = opa * opb;

  // Restoring divider step: dividend is 2^S, one quotient bit per cycle
  assign shift_rem = {rem_q, (cnt_q == '0)};
  assign rem_ge    = (shift_rem >= (VW+2)'(mod_i));

  // Final correction: remainder estimate is below 2p
  assign diff   = x_q - qp_q;
  assign diff_n = diff[VW:0];

  // Next state and datapath control
  always_comb begin
    state_d = state_q;
    recip_d = recip_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    done_d  = 1'b0;
    case (state_q)
      MM_IDLE: begin
        if (ctl_i.setup) begin
          rem_d   = '0;
          cnt_d   = '0;
          recip_d = '0;
          state_d = MM_DIV;
        end else if (ctl_i.start) begin
          state_d = MM_QUO;
        end
      end
      MM_DIV: begin
        rem_d   = rem_ge ? (VW+1)'(shift_rem - (VW+2)'(mod_i)) : shift_rem[VW:0];
        recip_d = {recip_q[OW-2:0], rem_ge};
        cnt_d   = cnt_q + CW'(1);
        if (cnt_q == CW'(S)) begin
          done_d  = 1'b1;
          state_d = MM_IDLE;
        end
      end
      MM_QUO: state_d = MM_QP;
      MM_QP:  state_d = MM_FIX;
      MM_FIX: begin
        res_d   = (diff_n >= mod_i) ? VW'(diff_n - mod_i) : diff_n[VW-1:0];
        done_d  = 1'b1;
        state_d = MM_IDLE;
      end
      default: state_d = MM_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MM_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    recip_q <= recip_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    res_q   <= res_d;
    if (state_q == MM_IDLE && ctl_i.start) begin
      x_q <= prod[S-1:0];
    end
    if (state_q == MM_QUO) begin
      q_q <= prod[2*S-1:S];
    end
    if (state_q == MM_QP) begin
      qp_q <= prod[S-1:0];
    end
  end

  assign stat_o.busy = (state_q != MM_IDLE);
  assign stat_o.done = done_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// File: rtl/power_residue_mask_top.sv
// Power residue mask: set of r^z mod p for all residues r below p.
//
// One request beat on in_i carries a modulus p and an exponent z; one result
// beat on out_o returns a 128-bit set (set_low = bits 0..63, set_high = bits
// 64..127) with bit k set when k = r^z mod p for some r < p. A modulus above
// SET_BITS is clamped to SET_BITS; a modulus of zero gives an empty set.
// The block takes one request at a time: in_i.ready is high only while idle.
// The reciprocal of p is computed once per request; then for each residue
// every exponent bit costs a modular square and every set bit of z an extra
// modular multiply, each through the single shared multiplier and its
// Barrett reduction.
// The result sits in an output register; a new request is taken while it
// waits, and a finished set is held until out_o.ready frees that register.
// Reset clears the sequencer and drops out_o.valid; no state is kept between
// requests.
`default_nettype none

module power_residue_mask_top #(
  parameter int unsigned SET_BITS = prm_pkg::SET_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  prm_in_if.sink   in_i,
  prm_out_if.source out_o
);
  import prm_pkg::*;

  localparam int unsigned IDX_W = $clog2(SET_BITS);
  localparam int unsigned CNT_W = $clog2(SET_BITS + 1);

  prm_state_e        state_q, state_d;
  logic [CNT_W-1:0]  p_q, p_d;
  logic [EXP_W-1:0]  z_q, z_d;
  logic [CNT_W-1:0]  r_q, r_d;
  logic [IDX_W-1:0]  acc_q, acc_d;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic [SET_BITS-1:0] set_q, set_d;
  logic              out_valid_q;
  logic [HALF_W-1:0] lo_q, hi_q;

  logic              in_ready;
  logic              load_out;
  logic [CNT_W-1:0]  p_clamp;
  logic [IDX_W-1:0]  acc_init;
  logic [SET_W-1:0]  set_ext;

  mm_ctl_t           mm_ctl;
  mm_stat_t          mm_stat;
  logic [IDX_W-1:0]  mm_a, mm_b, mm_res;

  // Modulus saturates at the set width
  assign p_clamp  = (in_i.modulus > MOD_W'(SET_BITS)) ? CNT_W'(SET_BITS)
                                                      : CNT_W'(in_i.modulus);
  // 1 mod p: zero when p is one
  assign acc_init = (p_q == CNT_W'(1)) ? '0 : IDX_W'(1);
  assign set_ext  = SET_W'(set_q);

  prm_modmul #(
    .VW (IDX_W)
  ) u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mm_ctl),
    .mod_i  ((IDX_W+1)'(p_q)),
    .a_i    (mm_a),
    .b_i    (mm_b),
    .stat_o (mm_stat),
    .res_o  (mm_res)
  );

  // Sequencer: residues outer, exponent bits MSB first inner
  always_comb begin
    state_d  = state_q;
    p_d      = p_q;
    z_d      = z_q;
    r_d      = r_q;
    acc_d    = acc_q;
    bit_d    = bit_q;
    set_d    = set_q;
    mm_ctl   = '0;
    mm_a     = acc_q;
    mm_b     = acc_q;
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          p_d     = p_clamp;
          z_d     = in_i.exponent;
          r_d     = '0;
          set_d   = '0;
          state_d = (p_clamp == '0) ? ST_DONE : ST_LOAD;
        end
      end
      ST_LOAD: begin
        mm_ctl.setup = 1'b1;
        state_d      = ST_SETUP;
      end
      ST_SETUP: begin
        if (mm_stat.done) begin
          acc_d   = acc_init;
          bit_d   = '1;
          state_d = ST_START;
        end
      end
      ST_START: begin
        if (r_q == p_q) begin
          state_d = ST_DONE;
        end else begin
          mm_ctl.start = 1'b1;
          state_d      = ST_SQW;
        end
      end
      ST_SQW: begin
        if (mm_stat.done) begin
          acc_d   = mm_res;
          state_d = z_q[bit_q] ? ST_MUL : ST_NEXT;
        end
      end
      ST_MUL: begin
        mm_b         = r_q[IDX_W-1:0];
        mm_ctl.start = 1'b1;
        state_d      = ST_MULW;
      end
      ST_MULW: begin
        if (mm_stat.done) begin
          acc_d   = mm_res;
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (bit_q == '0) begin
          // power done: mark it and move to the next residue
          set_d[acc_q] = 1'b1;
          r_d          = r_q + CNT_W'(1);
          acc_d        = acc_init;
          bit_d        = '1;
          state_d      = ST_START;
        end else begin
          bit_d        = bit_q - BIT_W'(1);
          mm_ctl.start = 1'b1;
          state_d      = ST_SQW;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    z_q   <= z_d;
    r_q   <= r_d;
    acc_q <= acc_d;
    bit_q <= bit_d;
    set_q <= set_d;
    if (load_out) begin
      lo_q <= set_ext[HALF_W-1:0];
      hi_q <= set_ext[SET_W-1:HALF_W];
    end
  end

  assign in_i.ready     = in_ready;
  assign out_o.valid    = out_valid_q;
  assign out_o.set_low  = lo_q;
  assign out_o.set_high = hi_q;

  // Multiplier completions only arrive while the sequencer waits for them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_stat.done |-> (state_q == ST_SETUP || state_q == ST_SQW || state_q == ST_MULW))
    else $error("modmul done outside a wait state");

  // Commands are never issued to a busy multiplier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mm_ctl.start || mm_ctl.setup) |-> !mm_stat.busy)
    else $error("modmul command while busy");

  // The running power stays a residue of p
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NEXT) |-> (CNT_W'(acc_q) < p_q))
    else $error("accumulator not reduced");

  // Residue counter never passes the modulus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (r_q <= p_q))
    else $error("residue counter overran modulus");

endmodule

`default_nettype wire

// File: tb/sv/tb_power_residue_mask_top.sv
// Self-checking testbench for power_residue_mask_top: random and directed requests.
`timescale 1ns / 100ps

module tb_power_residue_mask_top;
  import prm_pkg::*;

  localparam int unsigned SET_BITS      = SET_BITS_DEF;
  localparam int unsigned IDLE_PCT      = 34;
  localparam int unsigned HOLD_CYCLES   = 30000;  // long receiver stall, fills the block
  localparam int unsigned HOLD_AT       = 30;     // result count that triggers it
  localparam int unsigned SETTLE_CYCLES = 21000;  // just above worst-case latency
  localparam int unsigned RANDOM_ITEMS  = 121;

  typedef struct packed {
    logic [MOD_W-1:0] modulus;
    logic [EXP_W-1:0] exponent;
  } prm_req_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  prm_in_if  req_if ();
  prm_out_if res_if ();

  power_residue_mask_top #(.SET_BITS(SET_BITS)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (res_if)
  );

  always #5 clk_i = ~clk_i;

  prm_req_t         req_queue[$];   // requests waiting to be offered
  logic [SET_W-1:0] sets_due[$];    // predicted sets, oldest first
  prm_req_t         next_req;
  int unsigned      sent_count;
  int unsigned      got_count;
  int unsigned      hold_left;
  logic             hold_done;
  int unsigned      err_count = 0;

  // Set of r^z mod p over all r < p, modulus clamped to the set width
  function automatic logic [SET_W-1:0] residue_set(input logic [MOD_W-1:0] mod_in,
                                                   input logic [EXP_W-1:0] expo);
    int unsigned p;
    int unsigned acc;
    int unsigned b;
    logic [SET_W-1:0] s;
    s = '0;
    p = mod_in;
    if (p > SET_BITS) p = SET_BITS;
    for (int unsigned r = 0; r < p; r++) begin
      acc = 1 % p;
      b   = r % p;
      // square-and-multiply, MSB first over all exponent bits
      for (int i = EXP_W - 1; i >= 0; i--) begin
        acc = (acc * acc) % p;
        if (expo[i]) acc = (acc * b) % p;
      end
      s[acc] = 1'b1;
    end
    return s;
  endfunction

  // Request driver: record the prediction on each accepted beat, then refill
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid    <= 1'b0;
      req_if.modulus  <= '0;
      req_if.exponent <= '0;
      sent_count      <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        sets_due.push_back(residue_set(req_if.modulus, req_if.exponent));
        sent_count <= sent_count + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        // no idling while 60..99 requests have gone out
        if (req_queue.size() != 0 &&
            ((sent_count >= 60 && sent_count < 100) ||
             $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_req = req_queue.pop_front();
          req_if.modulus  <= next_req.modulus;
          req_if.exponent <= next_req.exponent;
          req_if.valid    <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result ready: random idling, one long hold, a quiet stretch with no idling
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else if (!hold_done && got_count == HOLD_AT) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      res_if.ready <= 1'b0;
    end else if (got_count >= 80 && got_count < 120) begin
      res_if.ready <= 1'b1;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Result monitor: compare each beat with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      got_count <= 0;
    end else if (res_if.valid && res_if.ready) begin
      got_count <= got_count + 1;
      if (sets_due.size() == 0) begin
        $error("unexpected result beat: set_low %h set_high %h",
               res_if.set_low, res_if.set_high);
        err_count++;
      end else begin
        if (res_if.set_low !== sets_due[0][HALF_W-1:0]) begin
          $error("set_low mismatch: expected %h, got %h",
                 sets_due[0][HALF_W-1:0], res_if.set_low);
          err_count++;
        end
        if (res_if.set_high !== sets_due[0][SET_W-1:HALF_W]) begin
          $error("set_high mismatch: expected %h, got %h",
                 sets_due[0][SET_W-1:HALF_W], res_if.set_high);
          err_count++;
        end
        void'(sets_due.pop_front());
      end
    end
  end

  // Wait until every request went out and every predicted set came back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (req_queue.size() != 0 || req_if.valid || sets_due.size() != 0);
  endtask

  task automatic add_req(input int unsigned m, input int unsigned e);
    prm_req_t r;
    r.modulus  = m[MOD_W-1:0];
    r.exponent = e[EXP_W-1:0];
    req_queue.push_back(r);
  endtask

  // Stimulus sequence
  initial begin
    int unsigned sel;
    int unsigned m;
    int unsigned e;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty modulus, modulus one, zero exponent, saturation,
    // 64-bit boundary, Fermat exponent, heavy exponents at full width
    add_req(0, 5);
    add_req(1, 0);
    add_req(2, 0);
    add_req(2, 1);
    add_req(3, 16'hFFFF);
    add_req(7, 3);
    add_req(11, 16'h7FFF);
    add_req(13, 16'h8000);
    add_req(64, 2);
    add_req(65, 3);
    add_req(97, 96);
    add_req(127, 16'h5555);
    add_req(128, 0);
    add_req(128, 1);
    add_req(128, 16'hAAAA);
    add_req(128, 16'hFFFF);
    add_req(129, 2);
    add_req(200, 16'h00FF);
    add_req(255, 16'hFFFF);

    // sender pause: let every directed result arrive first
    wait_drained();

    // random: mostly small moduli to keep the run short, a few large or clamped
    repeat (RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 6)       m = $urandom_range(0, 1);
      else if (sel < 86) m = $urandom_range(2, 24);
      else if (sel < 94) m = $urandom_range(25, 128);
      else               m = $urandom_range(129, 255);
      if ($urandom_range(0, 3) == 0) e = $urandom_range(0, 15);
      else                           e = $urandom_range(0, 16'hFFFF);
      add_req(m, e);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
